@@ design/irdg_pkg.sv @@
`timescale 1ns / 1ps
// Package of the incremental reachability guard: item structs, command and
// status codes, controller states and default sizes. No dependencies.
package irdg_pkg;

  localparam int NodeW    = 6;
  localparam int NodesDef = 64;

  typedef enum logic [1:0] {
    CmdCheckedInsert = 2'd0,
    CmdForcedInsert  = 2'd1,
    CmdQuery         = 2'd2,
    CmdClear         = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatAdded    = 2'd0,
    StatPresent  = 2'd1,
    StatRejected = 2'd2,
    StatDone     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StLook,
    StSweep,
    StClear,
    StResp
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [NodeW-1:0] src_node;
    logic [NodeW-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    reachable;
  } out_item_t;

endpackage

@@ design/irdg_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No package dependency.
module irdg_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/incremental_reachability_dag_guard.sv @@
`timescale 1ns / 1ps
// Incremental reachability guard for a directed graph of NODES nodes.
// Depends on irdg_pkg and on irdg_ram for the edge and reach matrices.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_item_i) takes one command item:
//    checked insert, forced insert, reachability query or clear all.
//  - Output channel (out_valid_o/out_ready_i/out_item_o) returns exactly one
//    result item per command: status, plus the reach bit for a query.
//  - Items are handled one at a time. A query or a refused insert passes
//    through a lookup state and a result state that loads its result into
//    the output register; an insert that updates the graph adds a sweep
//    that reads every row of the reach memory once through its single read
//    port; a clear zeroes one row of both memories per cycle before its result.
//  - in_ready_o rises in the same cycle as the result appears in the
//    output register.
//  - After reset the block sweeps both memories to zero and holds
//    in_ready_o low meanwhile.
//  - The result sits in an output register. The next item is accepted while
//    it waits; a stalled receiver holds the following result, and the input.
module incremental_reachability_dag_guard
  import irdg_pkg::*;
#(
  parameter int NODES = NodesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int AddrW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CntW  = $clog2(NODES + 1);
  localparam logic [NODES-1:0] RowOne = NODES'(1);

  // Controller registers
  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [AddrW-1:0] src_q, src_d;
  logic [AddrW-1:0] dst_q, dst_d;
  logic             ok_q, ok_d;
  logic [NODES-1:0] to_set_q, to_set_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AddrW-1:0] rd_row_q, rd_row_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // Memory ports
  logic             reach_we, edge_we;
  logic [AddrW-1:0] reach_waddr, edge_waddr, reach_raddr, edge_raddr;
  logic [NODES-1:0] reach_wdata, edge_wdata, reach_rdata, edge_rdata;

  logic [AddrW+NodeW-1:0] src_ext, dst_ext;
  logic                   accept;

  // Map the fixed-width node fields onto memory addresses
  assign src_ext = (AddrW + NodeW)'(in_item_i.src_node);
  assign dst_ext = (AddrW + NodeW)'(in_item_i.dst_node);

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  irdg_ram #(.Width(NODES), .Depth(NODES)) u_reach_ram (
    .clk_i  (clk_i),
    .we_i   (reach_we),
    .waddr_i(reach_waddr),
    .wdata_i(reach_wdata),
    .raddr_i(reach_raddr),
    .rdata_o(reach_rdata)
  );

  irdg_ram #(.Width(NODES), .Depth(NODES)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    ok_q     <= ok_d;
    to_set_q <= to_set_d;
    rd_row_q <= rd_row_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    src_d       = src_q;
    dst_d       = dst_q;
    ok_d        = ok_q;
    to_set_d    = to_set_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_row_d    = rd_row_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    reach_we    = 1'b0;
    reach_waddr = cnt_q[AddrW-1:0];
    reach_wdata = '0;
    reach_raddr = src_q;
    edge_we     = 1'b0;
    edge_waddr  = cnt_q[AddrW-1:0];
    edge_wdata  = '0;
    edge_raddr  = src_q;

    unique case (state_q)
      StInit, StClear: begin
        // Zero one row of both matrices per cycle
        reach_we = 1'b1;
        edge_we  = 1'b1;
        if (32'(cnt_q) == NODES - 1) begin
          cnt_d   = '0;
          state_d = (state_q == StClear) ? StResp : StIdle;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      StIdle: begin
        if (accept) begin
          cmd_d = in_item_i.cmd;
          src_d = src_ext[AddrW-1:0];
          dst_d = dst_ext[AddrW-1:0];
          ok_d  = (32'(in_item_i.src_node) < NODES) && (32'(in_item_i.dst_node) < NODES);
          // Queries read the src row of reach, inserts the dst row
          reach_raddr = (in_item_i.cmd == CmdQuery) ? src_ext[AddrW-1:0]
                                                    : dst_ext[AddrW-1:0];
          edge_raddr  = src_ext[AddrW-1:0];
          res_d.reachable = 1'b0;
          res_d.status    = StatDone;
          cnt_d           = '0;
          state_d = (in_item_i.cmd == CmdClear) ? StClear : StLook;
        end
      end

      StLook: begin
        res_d.reachable = 1'b0;
        state_d         = StResp;
        priority if (cmd_q == CmdQuery || cmd_q == CmdClear) begin
          res_d.status    = StatDone;
          res_d.reachable = ok_q && reach_rdata[dst_q];
        end else if (!ok_q) begin
          res_d.status = StatRejected;
        end else if (cmd_q == CmdCheckedInsert && edge_rdata[dst_q]) begin
          res_d.status = StatPresent;
        end else if (cmd_q == CmdCheckedInsert &&
                     (src_q == dst_q || reach_rdata[src_q])) begin
          res_d.status = StatRejected;
        end else begin
          // Mark the edge and snapshot reach of dst plus dst itself
          res_d.status = StatAdded;
          edge_we      = 1'b1;
          edge_waddr   = src_q;
          edge_wdata   = edge_rdata | (RowOne << dst_q);
          to_set_d     = reach_rdata | (RowOne << dst_q);
          cnt_d        = '0;
          state_d      = StSweep;
        end
      end

      StSweep: begin
        // Issue one row read per cycle; each row is read before it is rewritten
        if (32'(cnt_q) < NODES) begin
          reach_raddr = cnt_q[AddrW-1:0];
          rd_vld_d    = 1'b1;
          rd_row_d    = cnt_q[AddrW-1:0];
          cnt_d       = cnt_q + CntW'(1);
        end else if (!rd_vld_q) begin
          state_d = StResp;
        end
        // Rows that reach src, and src itself, take the snapshot
        if (rd_vld_q && (rd_row_q == src_q || reach_rdata[src_q])) begin
          reach_we    = 1'b1;
          reach_waddr = rd_row_q;
          reach_wdata = reach_rdata | to_set_q;
        end
      end

      StResp: begin
        // Hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          cnt_d       = '0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Only queries carry a reach bit
  a_reach_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != StatDone |-> !out_item_o.reachable)
    else $error("reachable set on a non-query result");

  // Every accepted non-clear item goes through the lookup cycle
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.cmd != CmdClear |=> state_q == StLook)
    else $error("accepted item skipped the lookup");

  // Outside a clearing pass, reach and edge rows are never written together
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_we && state_q != StClear && state_q != StInit |-> !reach_we)
    else $error("edge and reach written together outside a clear");

  // The sweep counter never runs past the row count
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSweep |-> 32'(cnt_q) <= NODES)
    else $error("sweep counter out of range");

  // A new result is loaded only when the previous one has left or is leaving
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StResp && out_valid_q && !out_ready_i |=> state_q == StResp)
    else $error("result overwritten while stalled");

endmodule

@@ dv/tb_incremental_reachability_dag_guard.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for incremental_reachability_dag_guard: directed
// graph cases, random and back-to-back traffic and an output stall, against
// its reach/edge matrix predictor. Depends on irdg_pkg and the block's RTL.
module tb_incremental_reachability_dag_guard;
  import irdg_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = NodesDef + 16;
  localparam int HoldCycles  = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // Predicted graph: direct edges and the transitive closure, one row per node.
  logic [NodesDef-1:0] edge_mx  [NodesDef];
  logic [NodesDef-1:0] reach_mx [NodesDef];

  // Results due from the block, oldest first.
  out_item_t   status_due [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          hold_cycles    = 0;
  bit          idle_en        = 1'b1;
  int unsigned node_pool [16];
  int unsigned pool_n         = 1;

  incremental_reachability_dag_guard uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Mark s->d and OR (reach of d, plus d) into s and every row that reaches s.
  // Take the set of rows to update before touching any of them.
  function automatic void link_nodes(input int unsigned s, input int unsigned d);
    logic [NodesDef-1:0] to_set;
    logic [NodesDef-1:0] from_set;
    edge_mx[s][d] = 1'b1;
    to_set        = reach_mx[d];
    to_set[d]     = 1'b1;
    for (int x = 0; x < NodesDef; x++) begin
      from_set[x] = (x == s) || reach_mx[x][s];
    end
    for (int x = 0; x < NodesDef; x++) begin
      if (from_set[x]) reach_mx[x] |= to_set;
    end
  endfunction

  function automatic void wipe_graph();
    for (int x = 0; x < NodesDef; x++) begin
      edge_mx[x]  = '0;
      reach_mx[x] = '0;
    end
  endfunction

  // Apply one command to the predicted graph and return the result it earns.
  function automatic out_item_t guard_predict(input in_item_t it);
    out_item_t   res;
    int unsigned s;
    int unsigned d;
    s             = 32'(it.src_node);
    d             = 32'(it.dst_node);
    res.status    = StatDone;
    res.reachable = 1'b0;
    case (it.cmd)
      CmdCheckedInsert: begin
        // an existing edge wins over the cycle check, even for a self-loop
        if (edge_mx[s][d]) begin
          res.status = StatPresent;
        end else if (s == d || reach_mx[d][s]) begin
          res.status = StatRejected;
        end else begin
          link_nodes(s, d);
          res.status = StatAdded;
        end
      end
      CmdForcedInsert: begin
        link_nodes(s, d);
        res.status = StatAdded;
      end
      CmdQuery: begin
        res.reachable = reach_mx[s][d];
      end
      CmdClear: begin
        wipe_graph();
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and result check
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the handshake, then predict its result.
  // Valid stays high into the next call unless an idle gap is drawn.
  task automatic send_cmd(input cmd_e c, input int unsigned s, input int unsigned d);
    in_item_t it;
    it.cmd      = c;
    it.src_node = s[NodeW-1:0];
    it.dst_node = d[NodeW-1:0];
    if (idle_en && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    status_due = {status_due, guard_predict(it)};
  endtask

  // Drop ready at random, or for a whole stretch while a hold is counting down.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99) < 6);
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 10) $display("%t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status=%0d reachable=%0d",
                                out_item_o.status, out_item_o.reachable));
      end else begin
        want = status_due.pop_front();
        if (out_item_o.status !== want.status) begin
          flag_mismatch($sformatf("status expected %0d got %0d",
                                  want.status, out_item_o.status));
        end
        if (out_item_o.reachable !== want.reachable) begin
          flag_mismatch($sformatf("reachable expected %0d got %0d",
                                  want.reachable, out_item_o.reachable));
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i) cycle_count++;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly draw from a small node pool so edges repeat, cycles close and
  // queries land on populated rows; now and then take any node.
  function automatic int unsigned pick_node();
    if ($urandom_range(9) == 0) return $urandom_range(NodesDef - 1);
    return node_pool[$urandom_range(pool_n - 1)];
  endfunction

  // Random traffic in epochs: each epoch takes a fresh pool and often
  // starts from an empty graph.
  task automatic run_random(input int n_items);
    int   epoch_left;
    int   r;
    cmd_e c;
    epoch_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (epoch_left == 0) begin
        pool_n = $urandom_range(3, 16);
        foreach (node_pool[i]) node_pool[i] = $urandom_range(NodesDef - 1);
        epoch_left = $urandom_range(30, 120);
        if ($urandom_range(1) == 1) send_cmd(CmdClear, $urandom_range(63), $urandom_range(63));
      end
      epoch_left--;
      r = $urandom_range(99);
      if (r < 52)      c = CmdCheckedInsert;
      else if (r < 57) c = CmdForcedInsert;
      else if (r < 98) c = CmdQuery;
      else             c = CmdClear;
      send_cmd(c, pick_node(), pick_node());
    end
  endtask

  // Extreme node numbers, every command and each refusal path.
  task automatic test_directed_cases();
    send_cmd(CmdQuery, 0, 63);           // empty graph reaches nothing
    send_cmd(CmdCheckedInsert, 0, 63);
    send_cmd(CmdCheckedInsert, 0, 63);   // existing edge
    send_cmd(CmdCheckedInsert, 63, 0);   // would close a cycle
    send_cmd(CmdCheckedInsert, 5, 5);    // self-loop
    send_cmd(CmdQuery, 0, 63);
    send_cmd(CmdQuery, 63, 0);
    send_cmd(CmdCheckedInsert, 63, 21);
    send_cmd(CmdQuery, 0, 21);           // reached through a path
    send_cmd(CmdCheckedInsert, 21, 0);   // cycle through a path
    send_cmd(CmdCheckedInsert, 42, 0);
    send_cmd(CmdQuery, 42, 21);
    send_cmd(CmdForcedInsert, 21, 0);    // forced cycle
    send_cmd(CmdQuery, 63, 63);
    send_cmd(CmdQuery, 42, 42);
    send_cmd(CmdForcedInsert, 0, 63);    // forced over an existing edge
    send_cmd(CmdForcedInsert, 42, 42);   // forced self-loop
    send_cmd(CmdCheckedInsert, 42, 42);  // now present, not rejected
    send_cmd(CmdQuery, 42, 42);
    send_cmd(CmdClear, 63, 63);
    send_cmd(CmdQuery, 0, 63);
    send_cmd(CmdCheckedInsert, 63, 0);   // fine once the graph is empty
    send_cmd(CmdQuery, 63, 0);
  endtask

  task automatic test_random_graphs();
    idle_en = 1'b1;
    run_random(1250);
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_random(150);
  endtask

  // Hold the receiver off while items keep coming, so the output register
  // fills and the block has to stall its input.
  task automatic test_output_hold();
    idle_en    = 1'b0;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_cycles = HoldCycles;
    @(posedge clk_i);
    run_random(40);
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    wipe_graph();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_graphs();
    test_output_hold();
    test_back_to_back();

    // Release the input, wait out every result, then let the block settle.
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
